// ===== hw/rtl/ktc_pkg.sv =====
`default_nettype none
package ktc_pkg;

    // timer modes, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_SET    = 6'b000010,
        MODE_DOWN   = 6'b000100,
        MODE_UP     = 6'b001000,
        MODE_PAUSED = 6'b010000,
        MODE_ALARM  = 6'b100000
    } t_mode;

    // mode codes as seen on the result port
    localparam logic [2:0] CODE_IDLE   = 3'd0;
    localparam logic [2:0] CODE_SET    = 3'd1;
    localparam logic [2:0] CODE_DOWN   = 3'd2;
    localparam logic [2:0] CODE_UP     = 3'd3;
    localparam logic [2:0] CODE_PAUSED = 3'd4;
    localparam logic [2:0] CODE_ALARM  = 3'd5;

    localparam int TIME_W = 13;
    localparam int SUB_W  = 16;

    localparam logic [TIME_W-1:0] SET_LIMIT    = 13'd5939;
    localparam logic [TIME_W-1:0] UP_LIMIT     = 13'd5999;
    localparam logic [TIME_W-1:0] SECS_PER_MIN = 13'd60;
    localparam logic [SUB_W-1:0]  TPS_RESET    = 16'd1000;

    // divide by 60: ceil(2^20 / 60), exact for every 13-bit value
    localparam logic [14:0] DIV60_RECIP = 15'd17477;
    localparam int          DIV60_SHIFT = 20;

    // register byte addresses
    localparam logic [1:0] ADDR_TPS = 2'd0;

    // state handed from the step stage to the format stage
    typedef struct packed {
        logic [TIME_W-1:0] shown;
        t_mode             mode;
    } t_view;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_IDLE:   c = CODE_IDLE;
            MODE_SET:    c = CODE_SET;
            MODE_DOWN:   c = CODE_DOWN;
            MODE_UP:     c = CODE_UP;
            MODE_PAUSED: c = CODE_PAUSED;
            MODE_ALARM:  c = CODE_ALARM;
            default:     c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kitchen_timer_controller_top.sv =====
// kitchen countdown / count-up timer controller
//
// input channel (i_valid / o_stall): one request per time tick, carrying the
// sampled levels of the minute and start/stop buttons
// output channel (o_valid / i_stall): one result per request with the shown
// minutes and seconds, the mode code and the buzzer flag
// config: apb-style port, ticks_per_second at byte address 0 (low 16 bits)
//
// three register stages: input register, timer state (step logic) and
// output register (divide by 60 through a reciprocal multiply)
// a request moves through the input register, the timer state and the output register in turn
// throughput is one request per cycle while i_stall is low; the state update
// loop stays within the timer state, so back-to-back ticks need no bubbles
//
// each stage moves on when the stage after it is empty or moving, so
// requests keep being taken while a result waits as long as a stage is free;
// o_stall rises only when all three stages hold data and i_stall is high
//
// reset (synchronous, i_rst_n low) empties the pipe, puts the timer in idle
// with zero time and sets ticks_per_second back to 1000
`default_nettype none
module kitchen_timer_controller_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // tick requests
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_minute_button,
    input  wire logic        i_start_button,

    // results
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_minutes_shown,
    output logic [5:0]       o_seconds_shown,
    output logic [2:0]       o_mode,
    output logic             o_buzzer_on,

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // stage valids
    logic r_v1;     // input register
    logic r_v2;     // timer state holds a finished step
    logic r_v3;     // output register

    // stage enables, back to front
    logic en1;
    logic en2;
    logic en3;

    logic r_min_in;
    logic r_start_in;

    logic [ktc_pkg::SUB_W-1:0] r_tps;

    ktc_pkg::t_view view;

    assign en3 = !r_v3 || !i_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_stall = !en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // button levels of the taken request
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_min_in   <= i_minute_button;
            r_start_in <= i_start_button;
        end
    end

    // config register, written on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= ktc_pkg::TPS_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ktc_pkg::ADDR_TPS) begin
            r_tps <= pwdata[ktc_pkg::SUB_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ktc_pkg::ADDR_TPS) ? {16'b0, r_tps} : 32'b0;

    // timer state advances once per request leaving the input register
    ktc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (r_v1 && en2),
        .i_minute (r_min_in),
        .i_start  (r_start_in),
        .i_tps    (r_tps),
        .o_view   (view)
    );

    // minutes / seconds split and output register
    ktc_fmt u_fmt (
        .i_clk     (i_clk),
        .i_load    (r_v2 && en3),
        .i_view    (view),
        .o_minutes (o_minutes_shown),
        .o_seconds (o_seconds_shown),
        .o_mode    (o_mode),
        .o_buzzer  (o_buzzer_on)
    );

    // stall only with a full pipe behind a stalled result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && i_stall))
        else $error("stall raised with a free stage");

    // buzzer follows the alarm code
    a_buzzer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_buzzer_on == (o_mode == ktc_pkg::CODE_ALARM)))
        else $error("buzzer does not match mode");

    // seconds field stays a valid remainder
    a_seconds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_seconds_shown < 6'd60))
        else $error("seconds out of range");

    // alarm always shows zero time
    a_alarm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mode == ktc_pkg::CODE_ALARM) |->
            (o_minutes_shown == 7'd0 && o_seconds_shown == 6'd0))
        else $error("alarm with nonzero time");

endmodule
`default_nettype wire

// ===== hw/rtl/ktc_step.sv =====
`default_nettype none
module ktc_step (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic                       i_minute,
    input  wire logic                       i_start,
    input  wire logic [ktc_pkg::SUB_W-1:0]  i_tps,
    output ktc_pkg::t_view                  o_view
);

    ktc_pkg::t_mode                r_mode,  n_mode;
    logic [ktc_pkg::TIME_W-1:0]    r_set,   n_set;
    logic [ktc_pkg::TIME_W-1:0]    r_shown, n_shown;
    logic [ktc_pkg::SUB_W-1:0]     r_sub,   n_sub;
    logic                          r_mprev, n_mprev;
    logic                          r_sprev, n_sprev;

    logic                          editable;
    logic                          push_min;
    logic                          push_start;
    logic                          clear;
    logic [ktc_pkg::SUB_W:0]       sub_next;
    logic                          sec;
    logic [ktc_pkg::SUB_W-1:0]     tick_sub;
    logic [ktc_pkg::TIME_W-1:0]    shown_dec;
    logic [ktc_pkg::TIME_W-1:0]    shown_inc;

    // sub-second phase and second strobe
    assign sub_next = {1'b0, r_sub} + {{ktc_pkg::SUB_W{1'b0}}, 1'b1};
    assign sec      = sub_next >= {1'b0, i_tps};
    assign tick_sub = sec ? '0 : sub_next[ktc_pkg::SUB_W-1:0];

    assign shown_dec = (sec && r_shown != '0) ? r_shown - 1'b1 : r_shown;
    assign shown_inc = (sec && r_shown < ktc_pkg::UP_LIMIT) ? r_shown + 1'b1 : r_shown;

    always_comb begin
        n_mode   = r_mode;
        n_set    = r_set;
        n_shown  = r_shown;
        n_sub    = r_sub;
        n_mprev  = i_minute;
        n_sprev  = i_start;
        clear    = 1'b0;

        editable   = r_mode inside {ktc_pkg::MODE_IDLE, ktc_pkg::MODE_SET,
                                    ktc_pkg::MODE_PAUSED};
        push_min   = editable && i_minute && !r_mprev;
        push_start = i_start && !r_sprev;

        if (push_min) begin
            n_set = (r_set > ktc_pkg::SET_LIMIT) ? '0 : r_shown + ktc_pkg::SECS_PER_MIN;
        end
        if (push_start && editable) begin
            n_sub = '0;
        end

        if (i_minute && i_start) begin
            clear = 1'b1;
        end else begin
            case (r_mode)
                ktc_pkg::MODE_SET: begin
                    n_shown = n_set;
                    if (!push_min && push_start) n_mode = ktc_pkg::MODE_DOWN;
                end
                ktc_pkg::MODE_DOWN: begin
                    n_sub   = tick_sub;
                    n_shown = shown_dec;
                    if (push_start) begin
                        n_mode = ktc_pkg::MODE_SET;
                        n_set  = shown_dec;
                    end else if (shown_dec == '0) begin
                        n_mode = ktc_pkg::MODE_ALARM;
                    end
                end
                ktc_pkg::MODE_UP: begin
                    n_sub   = tick_sub;
                    n_shown = shown_inc;
                    if (push_start) begin
                        n_mode = ktc_pkg::MODE_PAUSED;
                        n_set  = shown_inc;
                    end
                end
                ktc_pkg::MODE_PAUSED: begin
                    n_shown = n_set;
                    if (push_min)        n_mode = ktc_pkg::MODE_SET;
                    else if (push_start) n_mode = ktc_pkg::MODE_UP;
                end
                ktc_pkg::MODE_ALARM: begin
                    n_shown = '0;
                    if (push_start) clear = 1'b1;
                end
                ktc_pkg::MODE_IDLE: begin
                    if (push_min)        n_mode = ktc_pkg::MODE_SET;
                    else if (push_start) n_mode = ktc_pkg::MODE_UP;
                end
                default: begin
                end
            endcase
        end

        // both buttons held, or start in alarm
        if (clear) begin
            n_mode  = ktc_pkg::MODE_IDLE;
            n_set   = '0;
            n_shown = '0;
            n_sub   = '0;
            n_mprev = 1'b0;
            n_sprev = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ktc_pkg::MODE_IDLE;
            r_set   <= '0;
            r_shown <= '0;
            r_sub   <= '0;
            r_mprev <= 1'b0;
            r_sprev <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_set   <= n_set;
            r_shown <= n_shown;
            r_sub   <= n_sub;
            r_mprev <= n_mprev;
            r_sprev <= n_sprev;
        end
    end

    assign o_view.shown = r_shown;
    assign o_view.mode  = r_mode;

endmodule
`default_nettype wire

// ===== hw/rtl/ktc_fmt.sv =====
`default_nettype none
module ktc_fmt (
    input  wire logic           i_clk,
    input  wire logic           i_load,
    input  wire ktc_pkg::t_view i_view,
    output logic [6:0]          o_minutes,
    output logic [5:0]          o_seconds,
    output logic [2:0]          o_mode,
    output logic                o_buzzer
);

    logic [27:0]                   prod;
    logic [7:0]                    quot;
    logic [13:0]                   quot60;
    logic [ktc_pkg::TIME_W-1:0]    rem;

    logic [6:0] r_minutes;
    logic [5:0] r_seconds;
    logic [2:0] r_mode;
    logic       r_buzzer;

    // reciprocal multiply, then remainder by 64q - 4q
    assign prod   = 28'(i_view.shown) * 28'(ktc_pkg::DIV60_RECIP);
    assign quot   = prod[ktc_pkg::DIV60_SHIFT +: 8];
    assign quot60 = {quot, 6'b0} - {4'b0, quot, 2'b0};
    assign rem    = i_view.shown - quot60[ktc_pkg::TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_minutes <= quot[6:0];
            r_seconds <= rem[5:0];
            r_mode    <= ktc_pkg::mode_code(i_view.mode);
            r_buzzer  <= (i_view.mode == ktc_pkg::MODE_ALARM);
        end
    end

    assign o_minutes = r_minutes;
    assign o_seconds = r_seconds;
    assign o_mode    = r_mode;
    assign o_buzzer  = r_buzzer;

endmodule
`default_nettype wire

// ===== test/kitchen_timer_controller_checker.sv =====
module kitchen_timer_controller_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // tick request channel
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic        i_minute_button,
    input  wire logic        i_start_button,

    // result channel
    input  wire logic        i_res_valid,
    input  wire logic        i_res_stall,
    input  wire logic [6:0]  i_minutes_shown,
    input  wire logic [5:0]  i_seconds_shown,
    input  wire logic [2:0]  i_mode,
    input  wire logic        i_buzzer_on,

    // configuration bus, watched for register writes
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,

    output int               o_mismatches,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [12:0] SET_CEILING      = 13'd5939;
    localparam logic [12:0] COUNT_CEILING    = 13'd5999;
    localparam logic [12:0] MINUTE           = 13'd60;
    localparam logic [15:0] RATE_AFTER_RESET = 16'd1000;

    typedef struct packed {
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [2:0] mode;
        logic       buzzer;
    } t_display;

    // shadow of the timer
    logic [15:0] tick_rate;
    logic [2:0]  timer_mode;
    logic [12:0] set_secs;
    logic [12:0] shown_secs;
    logic [15:0] sub_ticks;
    logic        minute_was;
    logic        start_was;

    t_display views_due[$];

    function automatic void clear_timer();
        timer_mode = ktc_pkg::CODE_IDLE;
        set_secs   = '0;
        shown_secs = '0;
        sub_ticks  = '0;
        minute_was = 1'b0;
        start_was  = 1'b0;
    endfunction

    function automatic t_display current_view();
        t_display    v;
        logic [12:0] mins;
        logic [12:0] secs;
        mins      = shown_secs / MINUTE;
        secs      = shown_secs % MINUTE;
        v.minutes = mins[6:0];
        v.seconds = secs[5:0];
        v.mode    = timer_mode;
        v.buzzer  = (timer_mode == ktc_pkg::CODE_ALARM);
        return v;
    endfunction

    // sub-second phase, true when a whole second has gone by
    function automatic logic second_done();
        logic [16:0] nxt;
        nxt = {1'b0, sub_ticks} + 17'd1;
        if (nxt >= {1'b0, tick_rate}) begin
            sub_ticks = '0;
            return 1'b1;
        end
        sub_ticks = nxt[15:0];
        return 1'b0;
    endfunction

    function automatic t_display timer_next_view(input logic m, input logic s);
        logic [2:0] md;
        logic       editable;
        logic       push_min;
        logic       push_start;
        md       = timer_mode;
        editable = (md == ktc_pkg::CODE_IDLE) || (md == ktc_pkg::CODE_SET) ||
                   (md == ktc_pkg::CODE_PAUSED);

        push_min = editable && m && !minute_was;
        if (push_min) begin
            if (set_secs > SET_CEILING)
                set_secs = '0;
            else
                set_secs = shown_secs + MINUTE;
        end
        minute_was = m;

        push_start = s && !start_was;
        if (push_start && editable)
            sub_ticks = '0;
        start_was = s;

        // both buttons held wipes everything
        if (m && s) begin
            clear_timer();
            return current_view();
        end

        case (md)
            ktc_pkg::CODE_IDLE: begin
                if (push_min)
                    md = ktc_pkg::CODE_SET;
                else if (push_start)
                    md = ktc_pkg::CODE_UP;
            end
            ktc_pkg::CODE_SET: begin
                shown_secs = set_secs;
                if (!push_min && push_start)
                    md = ktc_pkg::CODE_DOWN;
            end
            ktc_pkg::CODE_DOWN: begin
                if (second_done() && shown_secs != 0)
                    shown_secs = shown_secs - 13'd1;
                if (push_start) begin
                    md       = ktc_pkg::CODE_SET;
                    set_secs = shown_secs;
                end else if (shown_secs == 0) begin
                    md = ktc_pkg::CODE_ALARM;
                end
            end
            ktc_pkg::CODE_UP: begin
                if (second_done() && shown_secs < COUNT_CEILING)
                    shown_secs = shown_secs + 13'd1;
                if (push_start) begin
                    set_secs = shown_secs;
                    md       = ktc_pkg::CODE_PAUSED;
                end
            end
            ktc_pkg::CODE_PAUSED: begin
                shown_secs = set_secs;
                if (push_min)
                    md = ktc_pkg::CODE_SET;
                else if (push_start)
                    md = ktc_pkg::CODE_UP;
            end
            ktc_pkg::CODE_ALARM: begin
                shown_secs = '0;
                if (push_start) begin
                    clear_timer();
                    return current_view();
                end
            end
            default: begin
            end
        endcase
        timer_mode = md;
        return current_view();
    endfunction

    task automatic flag(input string what, input logic [12:0] want, input logic [12:0] got);
        $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_display due;
        if (!i_rst_n) begin
            tick_rate = RATE_AFTER_RESET;
            clear_timer();
            views_due.delete();
            o_mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ktc_pkg::ADDR_TPS)
                tick_rate = pwdata[15:0];

            if (i_res_valid && !i_res_stall) begin
                if (views_due.size() == 0) begin
                    $display("%0t ns: result with no request pending, got %0d:%0d mode %0d",
                             $time, i_minutes_shown, i_seconds_shown, i_mode);
                    o_mismatches++;
                end else begin
                    due = views_due.pop_front();
                    if (due.minutes !== i_minutes_shown)
                        flag("minutes", 13'(due.minutes), 13'(i_minutes_shown));
                    if (due.seconds !== i_seconds_shown)
                        flag("seconds", 13'(due.seconds), 13'(i_seconds_shown));
                    if (due.mode !== i_mode)
                        flag("mode", 13'(due.mode), 13'(i_mode));
                    if (due.buzzer !== i_buzzer_on)
                        flag("buzzer", 13'(due.buzzer), 13'(i_buzzer_on));
                end
            end

            if (i_req_valid && !i_req_stall)
                views_due.push_back(timer_next_view(i_minute_button, i_start_button));
        end
        o_pending = views_due.size();
    end

endmodule

// ===== test/kitchen_timer_controller_top_tb.sv =====
module kitchen_timer_controller_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // receiver stall styles, each held for a stretch of cycles
    typedef enum int {
        STALL_NONE,
        STALL_SOME,
        STALL_HOLD
    } t_stall_style;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;

    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic        i_minute_button = 1'b0;
    logic        i_start_button  = 1'b0;

    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [6:0]  o_minutes_shown;
    logic [5:0]  o_seconds_shown;
    logic [2:0]  o_mode;
    logic        o_buzzer_on;

    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [1:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;

    int           mismatches;
    int           pending;
    int           burst_left  = 0;
    int           ticks_sent  = 0;
    int           stall_left  = 0;
    t_stall_style stall_style = STALL_NONE;

    // 100 MHz clock
    always #5 i_clk = ~i_clk;

    kitchen_timer_controller_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_minute_button (i_minute_button),
        .i_start_button  (i_start_button),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_minutes_shown (o_minutes_shown),
        .o_seconds_shown (o_seconds_shown),
        .o_mode          (o_mode),
        .o_buzzer_on     (o_buzzer_on),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // shadow timer and result compare live in the checker
    kitchen_timer_controller_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_minute_button (i_minute_button),
        .i_start_button  (i_start_button),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_minutes_shown (o_minutes_shown),
        .i_seconds_shown (o_seconds_shown),
        .i_mode          (o_mode),
        .i_buzzer_on     (o_buzzer_on),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // receiver back-pressure: free stretches, light random stalls and solid holds,
    // each lasting a random number of cycles so stalls land on every pipe phase
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 3))
                0, 1:    stall_style = STALL_SOME;
                2:       stall_style = STALL_NONE;
                default: stall_style = STALL_HOLD;
            endcase
            stall_left = (stall_style == STALL_HOLD) ? $urandom_range(1, 6)
                                                     : $urandom_range(4, 40);
        end
        stall_left--;
        case (stall_style)
            STALL_NONE: i_stall <= 1'b0;
            STALL_SOME: i_stall <= ($urandom_range(0, 2) == 0);
            default:    i_stall <= 1'b1;
        endcase
    end

    // one tick request; the sender runs in bursts with random gaps between them
    // and a request stays on the wires until it is taken
    task automatic send_tick(input logic m, input logic s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // a quarter of the bursts follow the previous one back to back
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_minute_button <= m;
        i_start_button  <= s;
        do @(posedge i_clk); while (o_stall);
        ticks_sent++;
    endtask

    // same button levels for n ticks in a row
    task automatic hold(input logic m, input logic s, input int n);
        repeat (n) send_tick(m, s);
    endtask

    // stop sending and let every outstanding result come back
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        // pipe is three stages deep, so keep idling after the last result is back
        repeat (4) @(negedge i_clk);
    endtask

    // apb write of the ticks-per-second register: setup then access
    task automatic program_tick_rate(input logic [15:0] rate);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ktc_pkg::ADDR_TPS;
        pwdata  <= {16'h0000, rate};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random phase: mostly button presses with releases and waits of random
    // length, plus both-button resets and some raw level noise
    task automatic random_phase(input int quota);
        int goal;
        int pick;
        goal = ticks_sent + quota;
        while (ticks_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                hold(1'b1, 1'b0, $urandom_range(1, 3));
                hold(1'b0, 1'b0, $urandom_range(1, 4));
            end else if (pick < 60) begin
                hold(1'b0, 1'b1, $urandom_range(1, 3));
                hold(1'b0, 1'b0, $urandom_range(1, 4));
            end else if (pick < 80) begin
                // long enough waits to let short countdowns run out
                hold(1'b0, 1'b0, $urandom_range(1, 60));
            end else if (pick < 88) begin
                hold(1'b1, 1'b1, $urandom_range(1, 3));
                hold(1'b0, 1'b0, 1);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        logic [15:0] rate;

        // synchronous reset, held low from time zero, then released
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed walk through the modes, ticks_per_second at its reset value
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);          // both buttons while idle
        send_tick(1'b0, 1'b0);
        hold(1'b1, 1'b0, 2);            // idle minute press, held: set mode, set time 1:00
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);          // second minute press in set mode
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);          // start from set: count down
        hold(1'b0, 1'b0, 3);
        send_tick(1'b0, 1'b1);          // start while counting down: back to set
        send_tick(1'b0, 1'b0);
        hold(1'b1, 1'b1, 2);            // both held over two ticks repeats the reset
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);          // idle start: count up
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);          // pause
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);          // resume counting up from pause
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);          // minute press while paused: set mode
        send_tick(1'b0, 1'b0);

        // --- one tick per second: countdown end, alarm and the set limit
        settle();
        program_tick_rate(16'd1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);          // set 1:00
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);          // count down from 60
        hold(1'b0, 1'b0, 59);           // down to 0:01
        send_tick(1'b0, 1'b1);          // start on the tick that reaches zero: set, not alarm
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);          // count down from zero
        send_tick(1'b0, 1'b0);          // reaches alarm, buzzer on
        send_tick(1'b1, 1'b0);          // minute press does nothing in alarm
        hold(1'b0, 1'b0, 2);
        send_tick(1'b0, 1'b1);          // start during alarm resets the timer
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);          // count up from idle
        hold(1'b0, 1'b0, 20);
        send_tick(1'b0, 1'b1);          // pause
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);          // minute press while paused: set mode
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        // minute presses up to 99:00, the one after that clears the set time to 0
        repeat (100) begin
            send_tick(1'b1, 1'b0);
            send_tick(1'b0, 1'b0);
        end

        // --- random phases, each under its own ticks-per-second setting
        for (int p = 0; p < 6; p++) begin
            settle();
            if (p == 0)
                rate = 16'd0;           // every tick counts as a second
            else if (p == 1)
                rate = 16'hffff;        // slowest setting
            else if ($urandom_range(0, 3) == 0)
                rate = 16'($urandom_range(4, 50));
            else
                rate = 16'($urandom_range(1, 3));
            program_tick_rate(rate);
            random_phase(40);
        end

        settle();
        if (mismatches == 0)
            $display("kitchen_timer_controller_top_tb: PASS");
        else
            $display("kitchen_timer_controller_top_tb: FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("kitchen_timer_controller_top_tb: FAIL");
        $finish;
    end

endmodule

// ===== kitchen_timer_controller_top.f =====
hw/rtl/ktc_pkg.sv
hw/rtl/ktc_step.sv
hw/rtl/ktc_fmt.sv
hw/rtl/kitchen_timer_controller_top.sv
test/kitchen_timer_controller_checker.sv
test/kitchen_timer_controller_top_tb.sv
